/* hdl/pss_pkg.sv */
package pss_pkg;

  localparam int unsigned RbWords   = 14;
  localparam int unsigned InitWords = 14;
  localparam int unsigned IdxW      = 4;

  // reply slots that hold the drive level of each channel
  localparam logic [IdxW-1:0] ReplySlotA = IdxW'(4);
  localparam logic [IdxW-1:0] ReplySlotB = IdxW'(5);

  localparam logic [8:0]  LevelFull = 9'h100;
  localparam logic [15:0] LevelMask = 16'h01FF;
  localparam logic [15:0] CtrlOn    = 16'h0100;
  localparam logic [15:0] Ch0Cmd    = 16'h4400;
  localparam logic [15:0] Ch1Cmd    = 16'h2400;
  localparam logic [15:0] ParityBit = 16'h4000;

  typedef enum logic [3:0] {
    PH_OFF      = 4'd0,
    PH_START0   = 4'd1,
    PH_START1   = 4'd2,
    PH_ON       = 4'd3,
    PH_INIT     = 4'd4,
    PH_READY    = 4'd5,
    PH_READBACK = 4'd6,
    PH_PROG     = 4'd7,
    PH_FAULT    = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    EM_STATUS = 2'd0,
    EM_INIT   = 2'd1,
    EM_RB     = 2'd2,
    EM_PROG   = 2'd3
  } emit_e;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_SCAN = 2'd1,
    SQ_WAIT = 2'd2
  } seq_state_e;

  // request from the sequencer to the transmit stage
  typedef struct packed {
    logic        start;
    emit_e       kind;
    logic        two;
    logic [15:0] pw0;
    logic [15:0] pw1;
    logic [3:0]  ctrl_state;
    logic        fault;
    logic        awake;
  } emit_req_t;

  function automatic logic [15:0] init_word(logic [IdxW-1:0] idx);
    logic [15:0] w;
    case (idx)
      4'd0:    w = 16'h5810;
      4'd1:    w = 16'h4400;
      4'd2:    w = 16'h2400;
      4'd3:    w = 16'h08E0;
      4'd4:    w = 16'h68E0;
      4'd5:    w = 16'h1026;
      4'd6:    w = 16'h7026;
      4'd7:    w = 16'h1400;
      4'd8:    w = 16'h7400;
      4'd9:    w = 16'h1980;
      4'd10:   w = 16'h4001;
      4'd11:   w = 16'h2001;
      4'd12:   w = 16'h0000;
      4'd13:   w = 16'hC006;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rb_word(logic [IdxW-1:0] idx);
    logic [15:0] w;
    case (idx)
      4'd0:    w = 16'h0000;
      4'd1:    w = 16'h4001;
      4'd2:    w = 16'h2001;
      4'd3:    w = 16'h4002;
      4'd4:    w = 16'h2002;
      4'd5:    w = 16'h0003;
      4'd6:    w = 16'h6003;
      4'd7:    w = 16'h4004;
      4'd8:    w = 16'h2004;
      4'd9:    w = 16'h0005;
      4'd10:   w = 16'h6005;
      4'd11:   w = 16'h0006;
      4'd12:   w = 16'h4007;
      4'd13:   w = 16'hC006;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] chk_mask(logic [IdxW-1:0] idx);
    logic [15:0] w;
    case (idx)
      4'd1:    w = 16'h3FBC;
      4'd2:    w = 16'h3F3F;
      4'd3:    w = 16'h3F3F;
      4'd4:    w = 16'h3E00;
      4'd5:    w = 16'h3E00;
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12:
               w = 16'h3FFF;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] chk_val(logic [IdxW-1:0] idx);
    logic [15:0] w;
    case (idx)
      4'd1:    w = 16'h0200;
      4'd2:    w = 16'h0600;
      4'd3:    w = 16'h2600;
      4'd4:    w = 16'h0A00;
      4'd5:    w = 16'h2A00;
      4'd6:    w = 16'h0EE0;
      4'd7:    w = 16'h2EE0;
      4'd8:    w = 16'h1226;
      4'd9:    w = 16'h3226;
      4'd10:   w = 16'h1600;
      4'd11:   w = 16'h3600;
      4'd12:   w = 16'h1B80;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] even_parity(logic [15:0] w);
    return (^w) ? (w ^ ParityBit) : w;
  endfunction

  function automatic logic [15:0] control_word(logic [8:0] level, logic fast,
                                               logic [7:0] cnt);
    logic [8:0] lv;
    logic [8:0] req;
    lv = (level > LevelFull) ? LevelFull : level;
    if (fast) begin
      req = lv;
    end else begin
      req = (lv > {1'b0, cnt}) ? LevelFull : 9'd0;
    end
    if (req == 9'd0) begin
      return 16'h0000;
    end
    return CtrlOn | {8'h00, 8'(req - 9'd1)};
  endfunction

endpackage

/* hdl/pss_if.sv */
interface pss_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        spi_idle;
  logic        turn_on;
  logic        turn_off;
  logic [8:0]  level_a;
  logic        fast_mode_a;
  logic [8:0]  level_b;
  logic        fast_mode_b;
  logic [3:0]  rx_index;
  logic [15:0] rx_word;

  modport source (
    output valid, op, spi_idle, turn_on, turn_off, level_a, fast_mode_a,
           level_b, fast_mode_b, rx_index, rx_word,
    input  ready
  );
  modport sink (
    input  valid, op, spi_idle, turn_on, turn_off, level_a, fast_mode_a,
           level_b, fast_mode_b, rx_index, rx_word,
    output ready
  );
endinterface

interface pss_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [15:0] tx_word;
  logic        tx_last;
  logic [3:0]  ctrl_state;
  logic        fault;
  logic        wake;
  logic        pwm_clock_on;

  modport source (
    output valid, tx_valid, tx_word, tx_last, ctrl_state, fault, wake, pwm_clock_on,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_word, tx_last, ctrl_state, fault, wake, pwm_clock_on,
    output ready
  );
endinterface

/* hdl/pss_reply_mem.sv */
module pss_reply_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [pss_pkg::IdxW-1:0] waddr_i,
  input  logic [15:0]              wdata_i,
  input  logic                     re_i,
  input  logic [pss_pkg::IdxW-1:0] raddr_i,
  output logic [15:0]              rdata_o
);
  import pss_pkg::*;

  logic [15:0] mem_q [RbWords];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pss_tx.sv */
module pss_tx (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pss_pkg::emit_req_t req_i,
  output logic               done_o,
  pss_out_if.source          out_o
);
  import pss_pkg::*;

  localparam logic [IdxW-1:0] InitLast = IdxW'(InitWords - 1);
  localparam logic [IdxW-1:0] RbLast   = IdxW'(RbWords - 1);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] k_q, k_d;
  emit_req_t       cur_q;
  logic [IdxW-1:0] last_idx;
  logic            is_last;
  logic            take;

  always_comb begin
    case (cur_q.kind)
      EM_INIT: last_idx = InitLast;
      EM_RB:   last_idx = RbLast;
      EM_PROG: last_idx = cur_q.two ? IdxW'(1) : IdxW'(0);
      default: last_idx = '0;
    endcase
  end

  assign is_last = (k_q == last_idx);
  assign take    = busy_q && out_o.ready;
  assign done_o  = take && is_last;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (take) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      cur_q <= req_i;
    end
  end

  always_comb begin
    out_o.valid        = busy_q;
    out_o.tx_valid     = (cur_q.kind != EM_STATUS);
    out_o.tx_last      = is_last;
    out_o.ctrl_state   = cur_q.ctrl_state;
    out_o.fault        = cur_q.fault;
    out_o.wake         = cur_q.awake;
    out_o.pwm_clock_on = cur_q.awake;
    case (cur_q.kind)
      EM_INIT: out_o.tx_word = init_word(k_q);
      EM_RB:   out_o.tx_word = rb_word(k_q);
      EM_PROG: out_o.tx_word = k_q[0] ? cur_q.pw1 : cur_q.pw0;
      default: out_o.tx_word = 16'h0000;
    endcase
  end

endmodule

/* hdl/pss_seq.sv */
module pss_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  pss_in_if.sink                   in_i,
  output logic                     mem_we_o,
  output logic [pss_pkg::IdxW-1:0] mem_waddr_o,
  output logic [15:0]              mem_wdata_o,
  output logic                     mem_re_o,
  output logic [pss_pkg::IdxW-1:0] mem_raddr_o,
  input  logic [15:0]              mem_rdata_i,
  output pss_pkg::emit_req_t       req_o,
  input  logic                     done_i
);
  import pss_pkg::*;

  localparam logic [RbWords-1:0] SeenAll = '1;
  localparam logic [IdxW-1:0]    ScanEnd = IdxW'(RbWords);

  seq_state_e       state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       slow_q, slow_d;
  logic [RbWords-1:0] seen_q, seen_d;
  logic [8:0]       lvl_a_q, lvl_a_d, lvl_b_q, lvl_b_d;
  logic             fast_a_q, fast_a_d, fast_b_q, fast_b_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic             prev_v_q, prev_v_d;
  logic [IdxW-1:0]  prev_idx_q, prev_idx_d;
  logic             bad_q, bad_d;
  logic [15:0]      r4_q, r4_d, r5_q, r5_d;

  logic               acc;
  logic               idx_ok;
  logic [RbWords-1:0] idx_onehot;
  logic               req_start;
  logic               go_scan;
  logic               rd_ok;
  logic               scan_end;
  logic               mism;
  logic [15:0]        c0, c1, w0, w1;
  logic               diff0, diff1;
  emit_req_t          req;

  assign acc    = in_i.valid && in_i.ready;
  assign idx_ok = (in_i.rx_index < IdxW'(RbWords));

  always_comb begin
    idx_onehot = '0;
    if (idx_ok) begin
      idx_onehot[in_i.rx_index] = 1'b1;
    end
  end

  // a tick that finds the phase ready with all replies in starts the check scan
  assign req_start = in_i.turn_on && (phase_q == PH_OFF || phase_q == PH_FAULT);
  assign go_scan   = acc && !in_i.op && !in_i.turn_off && !req_start &&
                     (phase_q == PH_READY) && (seen_q == SeenAll);

  assign rd_ok    = (scan_q < ScanEnd);
  assign scan_end = (state_q == SQ_SCAN) && !rd_ok;

  // readback data arrives in the cycle after its address
  assign mism = prev_v_q &&
                ((mem_rdata_i & chk_mask(prev_idx_q)) != chk_val(prev_idx_q));

  assign c0    = control_word(lvl_a_q, fast_a_q, slow_q);
  assign c1    = control_word(lvl_b_q, fast_b_q, slow_q);
  assign w0    = even_parity(Ch0Cmd | c0);
  assign w1    = even_parity(Ch1Cmd | c1);
  assign diff0 = ((r4_q & LevelMask) != c0);
  assign diff1 = ((r5_q & LevelMask) != c1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (acc) begin
          state_d = go_scan ? SQ_SCAN : SQ_WAIT;
        end
      end
      SQ_SCAN: begin
        if (scan_end) begin
          state_d = SQ_WAIT;
        end
      end
      SQ_WAIT: begin
        if (done_i) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    phase_d    = phase_q;
    slow_d     = slow_q;
    seen_d     = seen_q;
    lvl_a_d    = lvl_a_q;
    fast_a_d   = fast_a_q;
    lvl_b_d    = lvl_b_q;
    fast_b_d   = fast_b_q;
    scan_d     = scan_q;
    prev_v_d   = 1'b0;
    prev_idx_d = scan_q;
    bad_d      = bad_q;
    r4_d       = r4_q;
    r5_d       = r5_q;
    req        = '0;
    case (state_q)
      SQ_IDLE: begin
        if (acc) begin
          req.start = !go_scan;
          if (in_i.op) begin
            seen_d = seen_q | idx_onehot;
          end else begin
            slow_d   = slow_q + 8'd1;
            lvl_a_d  = in_i.level_a;
            fast_a_d = in_i.fast_mode_a;
            lvl_b_d  = in_i.level_b;
            fast_b_d = in_i.fast_mode_b;
            if (in_i.turn_off) begin
              phase_d = PH_OFF;
            end else if (req_start) begin
              phase_d = PH_START0;
            end else begin
              case (phase_q)
                PH_START0: phase_d = PH_START1;
                PH_START1: phase_d = PH_ON;
                PH_ON: begin
                  if (in_i.spi_idle) begin
                    phase_d  = PH_INIT;
                    req.kind = EM_INIT;
                  end
                end
                PH_INIT, PH_PROG: begin
                  if (in_i.spi_idle) begin
                    seen_d   = '0;
                    phase_d  = PH_READBACK;
                    req.kind = EM_RB;
                  end
                end
                PH_READBACK: begin
                  if (in_i.spi_idle) begin
                    phase_d = PH_READY;
                  end
                end
                PH_READY: begin
                  if (seen_q != SeenAll) begin
                    phase_d = PH_FAULT;
                  end else begin
                    scan_d = '0;
                    bad_d  = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      SQ_SCAN: begin
        prev_v_d = rd_ok;
        if (rd_ok) begin
          scan_d = scan_q + IdxW'(1);
        end
        bad_d = bad_q | mism;
        if (prev_v_q && prev_idx_q == ReplySlotA) begin
          r4_d = mem_rdata_i;
        end
        if (prev_v_q && prev_idx_q == ReplySlotB) begin
          r5_d = mem_rdata_i;
        end
        if (scan_end) begin
          req.start = 1'b1;
          if (bad_q || mism) begin
            phase_d = PH_FAULT;
          end else if (diff0 || diff1) begin
            phase_d  = PH_PROG;
            req.kind = EM_PROG;
            req.two  = diff0 && diff1;
            req.pw0  = diff0 ? w0 : w1;
            req.pw1  = w1;
          end else begin
            seen_d   = '0;
            phase_d  = PH_READBACK;
            req.kind = EM_RB;
          end
        end
      end
      default: ;
    endcase
    req.ctrl_state = phase_d;
    req.fault      = (phase_d == PH_FAULT);
    req.awake      = (phase_d >= PH_ON) && (phase_d <= PH_PROG);
  end

  // outputs
  always_comb begin
    in_i.ready  = (state_q == SQ_IDLE);
    mem_we_o    = acc && in_i.op && idx_ok;
    mem_waddr_o = in_i.rx_index;
    mem_wdata_o = in_i.rx_word;
    mem_re_o    = (state_q == SQ_SCAN) && rd_ok;
    mem_raddr_o = scan_q;
    req_o       = req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SQ_IDLE;
      phase_q  <= PH_OFF;
      slow_q   <= 8'd0;
      seen_q   <= '0;
      scan_q   <= '0;
      prev_v_q <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      slow_q   <= slow_d;
      seen_q   <= seen_d;
      scan_q   <= scan_d;
      prev_v_q <= prev_v_d;
      bad_q    <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_a_q    <= lvl_a_d;
    fast_a_q   <= fast_a_d;
    lvl_b_q    <= lvl_b_d;
    fast_b_q   <= fast_b_d;
    prev_idx_q <= prev_idx_d;
    r4_q       <= r4_d;
    r5_q       <= r5_d;
  end

endmodule

/* hdl/power_switch_spi_supervisor_core.sv */
// channel   dir  payload
// in_i      in   op spi_idle turn_on turn_off level_a/b fast_mode_a/b rx_index rx_word
// out_o     out  tx_valid tx_word tx_last ctrl_state fault wake pwm_clock_on
//
// one item at a time; every item gives 1, 2 or 14 result items, one per cycle while out_o is ready
// a ready tick with all replies in scans the reply memory, one entry per cycle
// through its single read port before the first result
// other items go straight to the transmit stage
// rst_ni is asynchronous; after reset the switch is off and no reply is seen
// out_o stalls hold the sequencer; in_i is not taken until the last result leaves
module power_switch_spi_supervisor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pss_in_if.sink    in_i,
  pss_out_if.source out_o
);
  import pss_pkg::*;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic [15:0]     mem_rdata;
  emit_req_t       req;
  logic            done;

  pss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .req_o       (req),
    .done_i      (done)
  );

  pss_reply_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pss_tx u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (done),
    .out_o  (out_o)
  );

endmodule
